@@ hdl/sorl_pkg.sv @@
// Shared types and codes for the size-ordered record list.
package sorl_pkg;

    localparam int SIZE_W   = 31;
    localparam int HANDLE_W = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_SORTED = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } sorl_entry_t;

    // Broadcast to every cell in the cycle an insert transaction is taken.
    typedef struct packed {
        logic        ins;
        logic        sorted;
        sorl_entry_t entry;
    } sorl_cmd_t;

endpackage

@@ hdl/sorl_cell.sv @@
// One table slot: holds an entry, compares it against the incoming size and shifts.
module sorl_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                  clk,
    input  sorl_pkg::sorl_cmd_t   cmd,
    input  logic [CNT_W-1:0]      count,
    input  sorl_pkg::sorl_entry_t prev_entry,
    input  logic                  hit_in,
    output logic                  hit_out,
    output sorl_pkg::sorl_entry_t entry
);
    import sorl_pkg::*;

    sorl_entry_t entry_reg;
    sorl_entry_t entry_next;
    logic        occupied;
    logic        at_end;
    logic        ge;
    logic        take_new;

    assign occupied = count > CNT_W'(INDEX);
    assign at_end   = count == CNT_W'(INDEX);
    assign ge       = cmd.sorted & occupied & (entry_reg.size >= cmd.entry.size);
    assign hit_out  = hit_in | ge;
    // First matching slot takes the new entry; with no match the slot at the end does.
    assign take_new = (ge & ~hit_in) | (~hit_out & at_end);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            // Slots ahead of the insertion point hold their entry.
            unique if (take_new)
            begin
                entry_next = cmd.entry;
            end
            else if (hit_in)
            begin
                entry_next = prev_entry;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hdl/size_ordered_record_list_unit.sv @@
// Top level of the size-ordered record list: cell chain, count and result register.
//
// Size-ordered record list. The table keeps up to CAPACITY entries, each a
// 31-bit size key and a 32-bit record handle, in a row of cells. Op 0 inserts
// an entry before the first stored entry whose size is greater than or equal
// to the new size (or at the end), op 1 appends at the end, op 2 reads the
// entry at a position, op 3 does nothing. Every transaction returns one result
// carrying a status (ok, full, bad position), the entry read (zero unless a
// good read), and the entry count after the transaction. In an insert,
// every cell compares its own size against the new one at once, a
// ripple of "match seen" flags through the chain picks the insertion slot,
// and all later cells shift one place toward the end on the same clock edge.
// A read selects one of the first 64 cells directly. So one transaction is
// accepted per clock unless a result is held in the output register and not
// taken; a new transaction is taken while the previous result is handed over.
// Reset empties the table by clearing the count only; the cells themselves
// are not cleared and need no clearing pass.
module size_ordered_record_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sorl_pkg::OP_W-1:0]      op,
    input  logic [sorl_pkg::SIZE_W-1:0]    record_size,
    input  logic [sorl_pkg::HANDLE_W-1:0]  record_handle,
    input  logic [sorl_pkg::POS_W-1:0]     position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sorl_pkg::STATUS_W-1:0]  status,
    output logic [sorl_pkg::SIZE_W-1:0]    read_size,
    output logic [sorl_pkg::HANDLE_W-1:0]  read_handle,
    output logic [sorl_pkg::COUNT_W-1:0]   entry_count
);
    import sorl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    // Only the cells a position field can reach need a read path.
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SIZE_W-1:0]   read_size_reg;
    logic [SIZE_W-1:0]   read_size_next;
    logic [HANDLE_W-1:0] read_handle_reg;
    logic [HANDLE_W-1:0] read_handle_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [COUNT_W-1:0]  entry_count_next;

    logic                accept;
    logic                full;
    logic                is_insert;
    logic                bad_pos;
    logic [EXT_W-1:0]    count_wide;
    sorl_cmd_t           cmd;
    sorl_entry_t         rd_entry;
    sorl_entry_t         cell_entry [CAPACITY];
    logic [CAPACITY:0]   hit;

    // Output register frees up whenever its result is taken.
    assign in_ready  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign is_insert = (op == OP_SORTED) | (op == OP_APPEND);
    assign bad_pos   = CMP_W'(position) >= CMP_W'(count_reg);

    assign cmd.ins          = accept & is_insert & ~full;
    assign cmd.sorted       = op == OP_SORTED;
    assign cmd.entry.size   = record_size;
    assign cmd.entry.handle = record_handle;

    // Cell chain; the match flag ripples from slot 0 toward the end.
    assign hit[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        sorl_entry_t prev_entry;
        if (g == 0)
        begin : g_head
            assign prev_entry = cmd.entry;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[g-1];
        end

        sorl_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .prev_entry (prev_entry),
            .hit_in     (hit[g]),
            .hit_out    (hit[g+1]),
            .entry      (cell_entry[g])
        );
    end

    // Read select over the reachable cells.
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (position == POS_W'(i))
            begin
                rd_entry = cell_entry[i];
            end
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        status_next      = ST_OK;
        read_size_next   = '0;
        read_handle_next = '0;
        unique case (op)
            OP_SORTED, OP_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (bad_pos)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    read_size_next   = rd_entry.size;
                    read_handle_next = rd_entry.handle;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign count_wide       = EXT_W'(count_next);
    assign entry_count_next = count_wide[COUNT_W-1:0];
    assign out_valid_next   = accept | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload: load on every accepted transaction, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            read_size_reg   <= read_size_next;
            read_handle_reg <= read_handle_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_size   = read_size_reg;
    assign read_handle = read_handle_reg;
    assign entry_count = entry_count_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the size-ordered record list unit.
`timescale 1ns / 1ps

import sorl_pkg::*;

localparam int LIST_CAPACITY = 64;

// Op code 3 has no meaning in the block; it must leave the table alone.
localparam logic [OP_W-1:0] OP_NOP = 2'd3;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
} list_result_t;

class record_list_checker;
    sorl_entry_t  model_entries[$];
    list_result_t pending_results[$];
    int errors = 0;
    int n_sorted = 0;
    int n_append = 0;
    int n_full = 0;
    int n_read = 0;
    int n_badpos = 0;
    int n_nop = 0;
    int n_checked = 0;

    // Update the table copy for an accepted transaction and queue its result.
    function void note_request(logic [OP_W-1:0] o, logic [SIZE_W-1:0] sz,
                               logic [HANDLE_W-1:0] hd, logic [POS_W-1:0] ps);
        list_result_t r;
        sorl_entry_t  e;
        int at;
        r = '0;
        e.size = sz;
        e.handle = hd;
        if (o == OP_SORTED || o == OP_APPEND)
        begin
            if (model_entries.size() >= LIST_CAPACITY)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                at = model_entries.size();
                // Scan from the end so the lowest matching slot wins.
                if (o == OP_SORTED)
                    for (int i = model_entries.size() - 1; i >= 0; i--)
                        if (model_entries[i].size >= sz)
                            at = i;
                model_entries.insert(at, e);
                if (o == OP_SORTED)
                    n_sorted++;
                else
                    n_append++;
            end
        end
        else if (o == OP_READ)
        begin
            if (int'(ps) >= model_entries.size())
            begin
                r.status = ST_BADPOS;
                n_badpos++;
            end
            else
            begin
                r.size = model_entries[ps].size;
                r.handle = model_entries[ps].handle;
                n_read++;
            end
        end
        else
            n_nop++;
        r.count = COUNT_W'(model_entries.size());
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [SIZE_W-1:0] sz,
                                 logic [HANDLE_W-1:0] hd, logic [COUNT_W-1:0] cnt);
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected: status 0x%0h, count %0d",
                     $time, st, cnt);
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        compare_field("status", 64'(want.status), 64'(st));
        compare_field("read_size", 64'(want.size), 64'(sz));
        compare_field("read_handle", 64'(want.handle), 64'(hd));
        compare_field("entry_count", 64'(want.count), 64'(cnt));
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS = 1125;
    localparam int QUIET_ITEMS  = 150;
    localparam int CHOKE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [SIZE_W-1:0]   SIZE_MAX   = {SIZE_W{1'b1}};
    localparam logic [HANDLE_W-1:0] HANDLE_MAX = {HANDLE_W{1'b1}};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     op;
    logic [SIZE_W-1:0]   record_size;
    logic [HANDLE_W-1:0] record_handle;
    logic [POS_W-1:0]    position;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   read_size;
    logic [HANDLE_W-1:0] read_handle;
    logic [COUNT_W-1:0]  entry_count;

    // Shared between the sender and the receiver process.
    bit quiet_tail = 1'b0;
    bit choke_request = 1'b0;

    record_list_checker sb = new();

    size_ordered_record_list_unit #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .record_size(record_size),
        .record_handle(record_handle),
        .position(position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .read_size(read_size),
        .read_handle(read_handle),
        .entry_count(entry_count)
    );

    always #2 clk = ~clk;

    // Present one transaction and hold it until the block takes it. Valid is
    // left high on return, so a back-to-back transaction never toggles it.
    task automatic send_op(input logic [OP_W-1:0] o, input logic [SIZE_W-1:0] sz,
                           input logic [HANDLE_W-1:0] hd, input logic [POS_W-1:0] ps);
        in_valid <= 1'b1;
        op <= o;
        record_size <= sz;
        record_handle <= hd;
        position <= ps;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(o, sz, hd, ps);
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Bias sizes toward a few small values so that equal keys are common,
    // with the extremes and full-width values mixed in.
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SIZE_MAX;
            2, 3, 4: return SIZE_W'($urandom_range(0, 7));
            5, 6: return SIZE_W'($urandom_range(0, 1000));
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    // Mostly valid positions, some just past the count, some anywhere.
    function automatic logic [POS_W-1:0] pick_position(input int cnt);
        int roll;
        roll = $urandom_range(0, 99);
        if (cnt == 0 || roll < 15)
            return POS_W'($urandom());
        if (roll < 30)
            return POS_W'(cnt);
        return POS_W'($urandom_range(0, cnt - 1));
    endfunction

    // Stimulus: reset, a directed opening, then random traffic.
    initial
    begin
        int cnt;
        int roll;
        int ins_pct;
        logic [OP_W-1:0] o;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_NOP;
        record_size <= '0;
        record_handle <= '0;
        position <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read an empty table, at both ends of the position range.
        send_op(OP_READ, '0, '0, '0);
        send_op(OP_READ, '0, '0, {POS_W{1'b1}});
        send_op(OP_NOP, SIZE_MAX, HANDLE_MAX, {POS_W{1'b1}});
        // Sorted inserts at the extremes of size and handle.
        send_op(OP_SORTED, SIZE_W'(100), '0, '0);
        send_op(OP_SORTED, '0, HANDLE_MAX, '0);
        send_op(OP_SORTED, SIZE_MAX, 32'hA5A5_A5A5, '0);
        // Equal key: must land ahead of the stored entry of the same size.
        send_op(OP_SORTED, SIZE_W'(100), 32'h1, '0);
        // Append a small key behind the maximum to break the ordering.
        send_op(OP_APPEND, SIZE_W'(5), 32'h2, '0);
        // Sorted inserts into the out-of-order table.
        send_op(OP_SORTED, SIZE_W'(50), 32'h3, '0);
        send_op(OP_SORTED, SIZE_W'(3), 32'h4, '0);
        send_op(OP_SORTED, SIZE_MAX, 32'h5, '0);
        send_op(OP_APPEND, '0, HANDLE_MAX, {POS_W{1'b1}});
        // Walk every stored entry, then step just past the count.
        for (int p = 0; p <= sb.model_entries.size(); p++)
            send_op(OP_READ, '0, '0, POS_W'(p));
        send_op(OP_NOP, '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            // Starve the output once, a third of the way in, while transactions keep coming.
            if (n == RANDOM_ITEMS / 3)
                choke_request = 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) < 15)
                idle_sender($urandom_range(1, 15));
            cnt = sb.model_entries.size();
            // Fill the table slowly so reads and inserts see every depth;
            // once full, keep probing the refusal path.
            ins_pct = (cnt < LIST_CAPACITY) ? 18 : 25;
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                o = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_SORTED;
            else if (roll < ins_pct + 5)
                o = OP_NOP;
            else
                o = OP_READ;
            send_op(o, pick_size(), HANDLE_W'($urandom()),
                    (o == OP_READ) ? pick_position(cnt) : POS_W'($urandom()));
        end
        in_valid <= 1'b0;

        // Drain, then keep clocking so the block can emit anything stray.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d sorted inserts, %0d appends, %0d refused on a full table.",
                 sb.n_sorted, sb.n_append, sb.n_full);
        $display("Covered %0d good reads, %0d reads past the count, %0d no-ops; %0d results.",
                 sb.n_read, sb.n_badpos, sb.n_nop, sb.n_checked);
        if (sb.errors == 0)
            $display("size_ordered_record_list_unit test passed");
        else
            $display("size_ordered_record_list_unit test failed");
        $finish;
    end

    // Receiver: check each accepted result, then decide ready for the next
    // cycle. Stall in random bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_response(status, read_size, read_handle, entry_count);
            if (choke_request)
            begin
                choke_request = 1'b0;
                stall_left = CHOKE_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < 12)
            begin
                stall_left = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("size_ordered_record_list_unit test failed");
        $finish;
    end

endmodule
